// ===== src/gcd_lcm_unit_macros.svh =====
// Assertion macros for the gcd_lcm_unit RTL files; gcdl_seq includes them.
// No dependencies; files that check properties include this header.
`ifndef GCD_LCM_UNIT_MACROS_SVH
`define GCD_LCM_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define GCDL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("gcd_lcm_unit assertion failed");
`define GCDL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gcd_lcm_unit implication failed");
`else
`define GCDL_ASSERT(lbl, clk, rstn, prop)
`define GCDL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/gcdl_pkg.sv =====
// Package for the GCD/LCM unit: widths, command and status codes, and the
// structs passed between the sequencer, the divider and the top level.
`default_nettype none
package gcdl_pkg;
  localparam int DATA_WIDTH = 32;
  localparam int OPERAND_W = 32;
  localparam int VALUE_W = 64;
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  localparam logic CMD_GCD = 1'b0;
  localparam logic CMD_LCM = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DATA_WIDTH-1:0] quot;
    logic [DATA_WIDTH-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic               status;
  } res_t;
endpackage
`default_nettype wire

// ===== src/gcdl_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on gcdl_pkg for widths and the request/response structs.
`default_nettype none
module gcdl_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gcdl_pkg::div_req_t req,
  output gcdl_pkg::div_rsp_t rsp
);
  import gcdl_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DATA_WIDTH-1:0] rem_r;
  logic [DATA_WIDTH-1:0] quo_r;
  logic [DATA_WIDTH-1:0] dvs_r;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  assign shifted = {rem_r, quo_r[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = ~diff[DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DATA_WIDTH);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo_r <= {quo_r[DATA_WIDTH-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;
endmodule
`default_nettype wire

// ===== src/gcdl_seq.sv =====
// Sequencer for the GCD/LCM unit: runs Euclid's remainder steps and the
// LCM division on the shared divider, then forms the product.
// Depends on gcdl_pkg and on gcdl_div through the request/response structs.
`default_nettype none
`include "gcd_lcm_unit_macros.svh"
module gcdl_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [gcdl_pkg::OPERAND_W-1:0]  in_operand_a,
  input  logic [gcdl_pkg::OPERAND_W-1:0]  in_operand_b,
  output gcdl_pkg::res_t                  res,
  input  logic                            res_ready,
  output gcdl_pkg::div_req_t              div_req,
  input  gcdl_pkg::div_rsp_t              div_rsp
);
  import gcdl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EUC  = 2'd1;
  localparam logic [1:0] S_LDIV = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  logic                  cmd_r;
  logic [DATA_WIDTH-1:0] a_r;
  logic [DATA_WIDTH-1:0] b_r;
  logic [DATA_WIDTH-1:0] small_r;
  logic [PROD_W-1:0]     value_r;
  logic                  status_r;
  logic [DATA_WIDTH-1:0] a_in;
  logic [DATA_WIDTH-1:0] b_in;
  logic                  accept;
  logic                  zero_op;
  logic                  rem_zero;
  logic [PROD_W-1:0]     prod;

  assign a_in     = in_operand_a[DATA_WIDTH-1:0];
  assign b_in     = in_operand_b[DATA_WIDTH-1:0];
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign zero_op  = (a_in == '0) || (b_in == '0);
  assign rem_zero = (div_rsp.rem == '0);
  assign prod     = PROD_W'(div_rsp.quot) * PROD_W'(b_r);

  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = small_r;
    div_req.divisor  = div_rsp.rem;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (zero_op) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt        = S_EUC;
            div_req.start    = 1'b1;
            div_req.dividend = a_in;
            div_req.divisor  = b_in;
          end
        end
      end
      S_EUC: begin
        if (div_rsp.done) begin
          if (!rem_zero) begin
            div_req.start = 1'b1;
          end else if (cmd_r == CMD_LCM) begin
            state_nxt        = S_LDIV;
            div_req.start    = 1'b1;
            div_req.dividend = a_r;
            div_req.divisor  = small_r;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_LDIV: begin
        if (div_rsp.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_command;
      a_r      <= a_in;
      b_r      <= b_in;
      small_r  <= b_in;
      value_r  <= '0;
      status_r <= zero_op ? STATUS_INVALID : STATUS_OK;
    end else if (state_r == S_EUC && div_rsp.done) begin
      if (rem_zero) begin
        value_r <= PROD_W'(small_r);
      end else begin
        small_r <= div_rsp.rem;
      end
    end else if (state_r == S_LDIV && div_rsp.done) begin
      value_r <= prod;
    end
  end

  assign res.valid  = (state_r == S_DONE);
  assign res.value  = VALUE_W'(value_r);
  assign res.status = status_r;

  `GCDL_ASSERT_IMPLY(a_start_state, clk, rst_n, div_req.start,
                     state_r == S_IDLE || state_r == S_EUC)
  `GCDL_ASSERT_IMPLY(a_done_state, clk, rst_n, div_rsp.done,
                     state_r == S_EUC || state_r == S_LDIV)
  `GCDL_ASSERT_IMPLY(a_ldiv_lcm, clk, rst_n, state_r == S_LDIV, cmd_r == CMD_LCM)
  `GCDL_ASSERT_IMPLY(a_invalid_zero, clk, rst_n,
                     res.valid && res.status == STATUS_INVALID, res.value == '0)
  `GCDL_ASSERT(a_euc_divisor, clk, rst_n, state_r != S_EUC || small_r != '0)
endmodule
`default_nettype wire

// ===== src/gcd_lcm_unit.sv =====
// Top level of the GCD/LCM unit: sequencer, shared divider, output register.
// Depends on gcdl_pkg, gcdl_div and gcdl_seq.
//
//   Channel | Ports                                      | Direction
//   in      | in_valid/in_ready, command, operand_a/_b   | request in
//   out     | out_valid/out_ready, value, status         | result out
//
// Each remainder step runs on the one shared divider.
// A request runs its Euclid remainder steps, plus one more division for LCM.
// A request with a zero operand skips the divider and goes straight to its result.
// Reset is synchronous and active low; it clears the control state only.
// A result waits in the output register, and the next request is taken meanwhile.
`default_nettype none
module gcd_lcm_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [gcdl_pkg::OPERAND_W-1:0] in_operand_a,
  input  logic [gcdl_pkg::OPERAND_W-1:0] in_operand_b,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gcdl_pkg::VALUE_W-1:0]   out_value,
  output logic                           out_status
);
  import gcdl_pkg::*;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  res_t               res;
  logic               res_ready;
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_status_r;

  gcdl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  gcdl_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .res          (res),
    .res_ready    (res_ready),
    .div_req      (div_req),
    .div_rsp      (div_rsp)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_value_r  <= res.value;
      out_status_r <= res.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for gcd_lcm_unit: a directed table of GCD and LCM requests, then random
// requests under four handshake pressure phases, checked against table values or a local predictor.
// Depends on gcdl_pkg and the gcd_lcm_unit RTL.
module tb;
  import gcdl_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_PER_PHASE = 220;
  localparam int TAIL_CYCLES = 4 * (DATA_WIDTH + 1);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } outcome_t;

  typedef struct packed {
    logic                 command;
    logic [OPERAND_W-1:0] a;
    logic [OPERAND_W-1:0] b;
    logic                 known;
    logic [VALUE_W-1:0]   want_value;
    logic                 want_status;
  } request_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_command = CMD_GCD;
  logic [OPERAND_W-1:0] in_operand_a = '0;
  logic [OPERAND_W-1:0] in_operand_b = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VALUE_W-1:0]   out_value;
  logic                 out_status;

  outcome_t pending_outcomes[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int checked_count = 0;
  int quiet_cycles = 0;
  int gcd_requests = 0;
  int lcm_requests = 0;
  int zero_requests = 0;
  int idle_by_phase[4] = '{0, 84, 0, 27};
  int stall_by_phase[4] = '{0, 0, 84, 27};

  request_row_t directed_rows [23] = '{
    '{CMD_GCD, 32'd0, 32'd7, 1'b1, 64'd0, STATUS_INVALID},
    '{CMD_GCD, 32'd9, 32'd0, 1'b1, 64'd0, STATUS_INVALID},
    '{CMD_LCM, 32'd0, 32'd0, 1'b1, 64'd0, STATUS_INVALID},
    '{CMD_LCM, 32'd0, 32'hFFFF_FFFF, 1'b1, 64'd0, STATUS_INVALID},
    '{CMD_LCM, 32'hFFFF_FFFF, 32'd0, 1'b1, 64'd0, STATUS_INVALID},
    '{CMD_GCD, 32'd1, 32'd1, 1'b1, 64'd1, STATUS_OK},
    '{CMD_LCM, 32'd1, 32'd1, 1'b1, 64'd1, STATUS_OK},
    '{CMD_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF, STATUS_OK},
    '{CMD_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF, STATUS_OK},
    '{CMD_GCD, 32'd1, 32'hFFFF_FFFF, 1'b1, 64'd1, STATUS_OK},
    '{CMD_LCM, 32'd1, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF, STATUS_OK},
    '{CMD_LCM, 32'hFFFF_FFFF, 32'd1, 1'b1, 64'hFFFF_FFFF, STATUS_OK},
    '{CMD_GCD, 32'h8000_0000, 32'h8000_0000, 1'b1, 64'h8000_0000, STATUS_OK},
    '{CMD_LCM, 32'h8000_0000, 32'h8000_0000, 1'b1, 64'h8000_0000, STATUS_OK},
    '{CMD_GCD, 32'd12, 32'd18, 1'b1, 64'd6, STATUS_OK},
    '{CMD_LCM, 32'd12, 32'd18, 1'b1, 64'd36, STATUS_OK},
    '{CMD_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 64'd0, STATUS_OK},
    '{CMD_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 64'd0, STATUS_OK},
    '{CMD_GCD, 32'd2971215073, 32'd1836311903, 1'b0, 64'd0, STATUS_OK},
    '{CMD_LCM, 32'd1836311903, 32'd2971215073, 1'b0, 64'd0, STATUS_OK},
    '{CMD_LCM, 32'h8000_0000, 32'hC000_0000, 1'b0, 64'd0, STATUS_OK},
    '{CMD_GCD, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 64'd0, STATUS_OK},
    '{CMD_LCM, 32'd7, 32'd7, 1'b1, 64'd7, STATUS_OK}
  };

  gcd_lcm_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_status   (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic outcome_t gcd_lcm_of(logic command, logic [OPERAND_W-1:0] a,
                                          logic [OPERAND_W-1:0] b);
    logic [DATA_WIDTH-1:0] x, y, big, sml, rem, g;
    outcome_t res;
    x = a[DATA_WIDTH-1:0];
    y = b[DATA_WIDTH-1:0];
    res.value = '0;
    res.status = STATUS_INVALID;
    if (x != '0 && y != '0) begin
      big = (x > y) ? x : y;
      sml = (x > y) ? y : x;
      g = sml;
      while (sml != '0) begin
        g = sml;
        rem = big % sml;
        big = sml;
        sml = rem;
      end
      res.status = STATUS_OK;
      if (command == CMD_GCD) begin
        res.value = VALUE_W'(g);
      end else begin
        res.value = VALUE_W'(x / g) * VALUE_W'(y);
      end
    end
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic command, input logic [OPERAND_W-1:0] a,
                              input logic [OPERAND_W-1:0] b, input outcome_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= command;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (!in_ready);
    pending_outcomes.push_back(want);
    if (want.status == STATUS_INVALID) begin
      zero_requests++;
    end else if (command == CMD_GCD) begin
      gcd_requests++;
    end else begin
      lcm_requests++;
    end
    @(negedge clk);
  endtask

  task automatic send_random_request();
    logic                 command;
    logic [OPERAND_W-1:0] a, b, k;
    int                   pick;
    command = ($urandom_range(1) == 0) ? CMD_GCD : CMD_LCM;
    pick = $urandom_range(99);
    a = $urandom();
    b = $urandom();
    if (pick < 5) begin
      case ($urandom_range(2))
        0: a = '0;
        1: b = '0;
        default: begin
          a = '0;
          b = '0;
        end
      endcase
    end else if (pick < 20) begin
      a = $urandom_range(255, 1);
      b = $urandom_range(255, 1);
    end else if (pick < 45) begin
      k = $urandom_range(65535, 1);
      a = k * $urandom_range(65535, 1);
      b = k * $urandom_range(65535, 1);
    end else if (pick < 55) begin
      b = $urandom_range(65535, 1);
      a = b * $urandom_range(65535, 1);
    end else if (pick < 60) begin
      b = a;
    end
    if ($urandom_range(1) == 1) begin
      {a, b} = {b, a};
    end
    send_request(command, a, b, gcd_lcm_of(command, a, b));
  endtask

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      checked_count++;
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result with no request outstanding: value=%h status=%b",
                   $time, out_value, out_status);
        end
      end else begin
        want = pending_outcomes.pop_front();
        if (out_value !== want.value || out_status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: expected value=%h status=%b, got value=%h status=%b",
                     $time, want.value, want.status, out_value, out_status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_outcomes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    request_row_t row;
    outcome_t     want;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.known) begin
        want.value = row.want_value;
        want.status = row.want_status;
      end else begin
        want = gcd_lcm_of(row.command, row.a, row.b);
      end
      send_request(row.command, row.a, row.b, want);
    end
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_by_phase[phase];
      recv_stall_pct = stall_by_phase[phase];
      repeat (RANDOM_PER_PHASE) send_random_request();
    end
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d GCD, %0d LCM and %0d zero-operand requests over four pressure phases.",
             gcd_requests, lcm_requests, zero_requests);
    $display("Compared %0d results, %0d mismatches.", checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/gcdl_pkg.sv
src/gcdl_div.sv
src/gcdl_seq.sv
src/gcd_lcm_unit.sv
verif/tb.sv
